// File: sv/pcs_pkg.sv
// shared types, codes and payload decode for the port command store
`default_nettype none

package pcs_pkg;

  // operation codes of an input item
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_PORT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_RETRY_GAP   = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  // reset values of the configuration registers
  localparam logic [5:0] PORT_COUNT_RST  = 6'd32;
  localparam logic [7:0] RETRY_GAP_RST   = 8'd2;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  // payload bytes
  localparam logic [7:0] PAY_FIRST_HIGH = 8'h03;
  localparam logic [7:0] PAY_FIRST_LOW  = 8'h01;
  localparam logic [7:0] PAY_SECOND_ON  = 8'h10;

  // port command codes
  typedef enum logic [1:0] {
    CMD_OFF  = 2'd0,
    CMD_HIGH = 2'd1,
    CMD_LOW  = 2'd2
  } cmd_e;

  // result of the pending scan
  typedef struct packed {
    logic       found;
    logic [4:0] port;
  } sel_t;

  // set and clear requests for the pending flags
  typedef struct packed {
    logic       set;
    logic [4:0] set_port;
    logic       clr;
    logic [4:0] clr_port;
  } pend_upd_t;

  function automatic logic [7:0] pay_first(input logic [1:0] cmd);
    logic [7:0] res;
    case (cmd)
      CMD_HIGH: res = PAY_FIRST_HIGH;
      CMD_LOW:  res = PAY_FIRST_LOW;
      default:  res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] pay_second(input logic [1:0] cmd);
    logic [7:0] res;
    case (cmd)
      CMD_HIGH: res = PAY_SECOND_ON;
      CMD_LOW:  res = PAY_SECOND_ON;
      default:  res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/pcs_cmd_mem.sv
// command memory: one write port, one registered read port
`default_nettype none

module pcs_cmd_mem import pcs_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [1:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [1:0]         rdata_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/pcs_pend_sel.sv
// pending flags and lowest-pending-port priority encoder
`default_nettype none

module pcs_pend_sel import pcs_pkg::*; #(
  parameter int unsigned PORTS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pend_upd_t  upd_i,
  input  wire logic [5:0] limit_i,
  output sel_t            sel_o
);

  localparam int unsigned PW = $clog2(PORTS);

  logic [PORTS-1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      if (upd_i.set) begin
        pend_q[upd_i.set_port[PW-1:0]] <= 1'b1;
      end
      if (upd_i.clr) begin
        pend_q[upd_i.clr_port[PW-1:0]] <= 1'b0;
      end
    end
  end

  // lowest flagged port below the scan limit wins
  always_comb begin
    sel_o = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (pend_q[i] && (6'(i) < limit_i)) begin
        sel_o.found = 1'b1;
        sel_o.port  = 5'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/port_command_store_with_resend.sv
// top level of the port command store with resend
`default_nettype none

//  channel   direction  handshake                 payload
//  ------------------------------------------------------------------------------
//  in        input      in_valid_i / in_ready_o   operation, port, command, now
//  out       output     out_valid_o / out_ready_i send_*, payload_*, pins, shift_*,
//                                                 retry_count
//  cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
//  the pending scan, the retry update and the command memory access all happen at the
//  accepting edge, the result appears the cycle after
//  reset clears the pending flags, pins, retry tracking and restores config defaults
//  the command memory has no reset; the user must only let a port a command wrote be read,
//  the block does not enforce it; a new item is taken while the output register is empty or
//  being emptied, so a stalled output holds the input off and the result stays stable

module port_command_store_with_resend import pcs_pkg::*; #(
  parameter int unsigned PORTS        = 32,
  parameter int unsigned DIRECT_PORTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [4:0]  port_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] now_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             send_valid_o,
  output logic [4:0]       send_port_o,
  output logic [7:0]       payload_first_o,
  output logic [7:0]       payload_second_o,
  output logic [3:0]       high_side_pins_o,
  output logic [3:0]       low_side_pins_o,
  output logic             shift_write_o,
  output logic [31:0]      shift_word_o,
  output logic [3:0]       retry_count_o
);

  localparam int unsigned AW      = $clog2(PORTS);
  localparam logic [5:0]  PortsW  = 6'(PORTS);
  localparam logic [5:0]  DirectW = 6'(DIRECT_PORTS);
  localparam logic [4:0]  DirectP = 5'(DIRECT_PORTS);

  // configuration registers
  logic [5:0] port_count_q;
  logic [7:0] retry_gap_q;
  logic [3:0] retry_limit_q;

  // retry tracking and pin state
  logic [4:0]              last_port_q, last_port_d;
  logic [31:0]             last_time_q, last_time_d;
  logic [3:0]              retries_q, retries_d;
  logic [DIRECT_PORTS-1:0] high_q, high_d;
  logic [DIRECT_PORTS-1:0] low_q, low_d;

  // output register
  logic        out_valid_q;
  logic        send_valid_q;
  logic [4:0]  send_port_q;
  logic        shift_write_q, shift_write_d;
  logic [31:0] shift_word_q, shift_word_d;

  logic        accept;
  logic        is_cmd;
  logic        port_ok;
  logic        is_direct;
  logic        mem_we;
  logic        svc;
  logic        same_retry;
  logic        lim_hit;
  logic        pend_set;
  logic        pend_clr;
  logic [3:0]  r_next;
  logic [31:0] elapsed;
  logic [4:0]  shift_idx;
  logic [5:0]  limit;
  logic [1:0]  rd_cmd;
  sel_t        sel;
  pend_upd_t   upd;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_count_q  <= PORT_COUNT_RST;
      retry_gap_q   <= RETRY_GAP_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PORT_COUNT:  port_count_q  <= cfg_data_i[5:0];
        CFG_RETRY_GAP:   retry_gap_q   <= cfg_data_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // scan range clamps to the number of ports built
  assign limit = (port_count_q > PortsW) ? PortsW : port_count_q;

  assign is_cmd    = accept && (operation_i == OP_COMMAND);
  assign port_ok   = {1'b0, port_i} < PortsW;
  assign is_direct = {1'b0, port_i} < DirectW;

  // shift ports count from the first port after the direct ports, bit order reversed in a byte
  assign shift_idx = (port_i - DirectP) ^ 5'd7;

  // command item: pins, memory write, pending set and shift word
  always_comb begin
    high_d        = high_q;
    low_d         = low_q;
    mem_we        = 1'b0;
    pend_set      = 1'b0;
    shift_write_d = 1'b0;
    shift_word_d  = '0;
    if (is_cmd && port_ok) begin
      if (is_direct) begin
        // unknown code still marks pending but leaves pins and command alone
        pend_set = 1'b1;
        for (int i = 0; i < DIRECT_PORTS; i++) begin
          if (port_i == 5'(i)) begin
            case (command_i)
              CMD_HIGH: begin
                low_d[i]  = 1'b1;
                high_d[i] = 1'b0;
              end
              CMD_LOW: begin
                low_d[i]  = 1'b0;
                high_d[i] = 1'b1;
              end
              CMD_OFF: begin
                low_d[i]  = 1'b0;
                high_d[i] = 1'b0;
              end
              default: ;
            endcase
          end
        end
        case (command_i)
          CMD_HIGH, CMD_LOW, CMD_OFF: mem_we = 1'b1;
          default: ;
        endcase
      end else begin
        // low or unknown code on a shift port is dropped entirely
        case (command_i)
          CMD_OFF: begin
            mem_we        = 1'b1;
            pend_set      = 1'b1;
            shift_write_d = 1'b1;
          end
          CMD_HIGH: begin
            mem_we        = 1'b1;
            pend_set      = 1'b1;
            shift_write_d = 1'b1;
            shift_word_d  = 32'd1 << shift_idx;
          end
          default: ;
        endcase
      end
    end
  end

  // service item: retry counting on the selected port
  assign svc        = accept && (operation_i == OP_SERVICE) && sel.found;
  assign elapsed    = now_i - last_time_q;
  assign same_retry = (elapsed > {24'd0, retry_gap_q}) && (sel.port == last_port_q);
  assign r_next     = same_retry ? (retries_q + 4'd1) : 4'd0;
  assign lim_hit    = r_next >= retry_limit_q;

  always_comb begin
    last_port_d = last_port_q;
    last_time_d = last_time_q;
    retries_d   = retries_q;
    pend_clr    = 1'b0;
    if (svc) begin
      last_port_d = sel.port;
      last_time_d = now_i;
      retries_d   = lim_hit ? 4'd0 : r_next;
      pend_clr    = lim_hit;
    end
  end

  // set comes from a command item, clear from a service item at the limit
  assign upd = '{set: pend_set, set_port: port_i, clr: pend_clr, clr_port: sel.port};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_port_q <= '0;
      last_time_q <= '0;
      retries_q   <= '0;
      high_q      <= '0;
      low_q       <= '0;
    end else begin
      last_port_q <= last_port_d;
      last_time_q <= last_time_d;
      retries_q   <= retries_d;
      high_q      <= high_d;
      low_q       <= low_d;
    end
  end

  pcs_pend_sel #(
    .PORTS (PORTS)
  ) u_pend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .limit_i (limit),
    .sel_o   (sel)
  );

  // read of the selected port lands together with the output register
  pcs_cmd_mem #(
    .DEPTH (PORTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (port_i[AW-1:0]),
    .wdata_i (command_i),
    .re_i    (svc),
    .raddr_i (sel.port[AW-1:0]),
    .rdata_o (rd_cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      send_valid_q  <= svc;
      send_port_q   <= svc ? sel.port : 5'd0;
      shift_write_q <= shift_write_d;
      shift_word_q  <= shift_word_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign send_valid_o     = send_valid_q;
  assign send_port_o      = send_port_q;
  assign payload_first_o  = send_valid_q ? pay_first(rd_cmd) : 8'h00;
  assign payload_second_o = send_valid_q ? pay_second(rd_cmd) : 8'h00;
  assign shift_write_o    = shift_write_q;
  assign shift_word_o     = shift_word_q;
  // state only moves on accept, which is also when the old result leaves
  assign retry_count_o    = retries_q;

  for (genvar g = 0; g < 4; g++) begin : g_pins
    if (g < DIRECT_PORTS) begin : g_on
      assign high_side_pins_o[g] = high_q[g];
      assign low_side_pins_o[g]  = low_q[g];
    end else begin : g_off
      assign high_side_pins_o[g] = 1'b0;
      assign low_side_pins_o[g]  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the port command store with resend
`default_nettype none

// what is covered
//   command items on the direct ports (pin pairs, inverted for high) and on
//   the shift ports (one-hot word, low and code three ignored)
//   service items: lowest pending port below the port count, retry counting
//   across the wrap of the tick, pending cleared at the retry limit
//   port count zero, one and above the port total, retry limit zero and max
//   random stretches of commands followed by resends, plus noise items
// how
//   a predictor in this file tracks the command table, pending flags, pins and
//   retry state; each accepted item pushes one expected result and each
//   accepted result is compared field by field with the oldest one

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam int PORTS          = 32;
  localparam int DIRECT_PORTS   = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 175;

  // command code that has no meaning, kept as a name of its own
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic        send_valid;
    logic [4:0]  send_port;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
    logic [3:0]  high_pins;
    logic [3:0]  low_pins;
    logic        shift_write;
    logic [31:0] shift_word;
    logic [3:0]  retry_count;
  } port_result_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_PORT_COUNT;
  logic [7:0]  cfg_data_i  = 8'd0;
  logic        in_valid_i  = 1'b0;
  logic        operation_i = OP_COMMAND;
  logic [4:0]  port_i      = 5'd0;
  logic [1:0]  command_i   = CMD_OFF;
  logic [31:0] now_i       = 32'd0;
  logic        out_ready_i = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic        send_valid_o;
  logic [4:0]  send_port_o;
  logic [7:0]  payload_first_o;
  logic [7:0]  payload_second_o;
  logic [3:0]  high_side_pins_o;
  logic [3:0]  low_side_pins_o;
  logic        shift_write_o;
  logic [31:0] shift_word_o;
  logic [3:0]  retry_count_o;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  port_command_store_with_resend #(
    .PORTS        (PORTS),
    .DIRECT_PORTS (DIRECT_PORTS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .port_i           (port_i),
    .command_i        (command_i),
    .now_i            (now_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .send_valid_o     (send_valid_o),
    .send_port_o      (send_port_o),
    .payload_first_o  (payload_first_o),
    .payload_second_o (payload_second_o),
    .high_side_pins_o (high_side_pins_o),
    .low_side_pins_o  (low_side_pins_o),
    .shift_write_o    (shift_write_o),
    .shift_word_o     (shift_word_o),
    .retry_count_o    (retry_count_o)
  );

  // ---------------------------------------------------------------------------
  // shadow state of the block: config copy, command table and retry tracking
  // ---------------------------------------------------------------------------
  logic [5:0]  cfg_port_count  = PORT_COUNT_RST;
  logic [7:0]  cfg_retry_gap   = RETRY_GAP_RST;
  logic [3:0]  cfg_retry_limit = RETRY_LIMIT_RST;

  logic [1:0]  port_cmd     [PORTS];
  bit          port_pending [PORTS];
  bit          cmd_written  [PORTS];   // guards code three on a never written port
  logic [4:0]  last_port    = 5'd0;
  logic [31:0] last_time    = 32'd0;
  logic [3:0]  retries      = 4'd0;
  logic [3:0]  hi_pins      = 4'd0;
  logic [3:0]  lo_pins      = 4'd0;

  port_result_t due_results_q[$];
  int           mismatch_count = 0;

  // shared knobs between the tests and the idling processes
  bit idle_on      = 1'b1;
  int hold_request = 0;

  initial begin
    for (int i = 0; i < PORTS; i++) begin
      port_cmd[i]     = CMD_OFF;
      port_pending[i] = 1'b0;
      cmd_written[i]  = 1'b0;
    end
  end

  // apply one accepted item to the shadow state and return its result
  function automatic port_result_t apply_port_item(input logic op, input logic [4:0] port,
                                                   input logic [1:0] cmd,
                                                   input logic [31:0] now);
    port_result_t res;
    logic [3:0]   pin_mask;
    logic [31:0]  elapsed;
    logic [1:0]   sent_cmd;
    int           scan_end;
    int           grp;
    int           shift_pos;
    bit           hit;
    res = '0;
    if (op == OP_COMMAND) begin
      if (port < DIRECT_PORTS) begin
        pin_mask = 4'b0001 << port[1:0];
        case (cmd)
          CMD_HIGH: begin
            lo_pins = lo_pins | pin_mask;
            hi_pins = hi_pins & ~pin_mask;
          end
          CMD_LOW: begin
            lo_pins = lo_pins & ~pin_mask;
            hi_pins = hi_pins | pin_mask;
          end
          CMD_OFF: begin
            lo_pins = lo_pins & ~pin_mask;
            hi_pins = hi_pins & ~pin_mask;
          end
          default: ;
        endcase
        // code three keeps command and pins but still marks the port
        if (cmd != CMD_UNUSED) begin
          port_cmd[port]    = cmd;
          cmd_written[port] = 1'b1;
        end
        port_pending[port] = 1'b1;
      end else if (cmd == CMD_OFF) begin
        port_cmd[port]     = CMD_OFF;
        cmd_written[port]  = 1'b1;
        port_pending[port] = 1'b1;
        res.shift_write    = 1'b1;
      end else if (cmd == CMD_HIGH) begin
        // bits run msb first inside each byte of the chain
        grp       = int'(port) - DIRECT_PORTS;
        shift_pos = 8 * (grp / 8) + (7 - grp % 8);
        port_cmd[port]     = CMD_HIGH;
        cmd_written[port]  = 1'b1;
        port_pending[port] = 1'b1;
        res.shift_write    = 1'b1;
        res.shift_word     = 32'd1 << shift_pos;
      end
    end else begin
      scan_end = (cfg_port_count > PORTS) ? PORTS : int'(cfg_port_count);
      hit      = 1'b0;
      for (int i = 0; i < scan_end; i++) begin
        if (!hit && port_pending[i]) begin
          hit      = 1'b1;
          sent_cmd = port_cmd[i];
          elapsed  = now - last_time;
          if (elapsed > {24'd0, cfg_retry_gap} && last_port == i[4:0]) begin
            retries = retries + 4'd1;
          end else begin
            last_port = i[4:0];
            retries   = 4'd0;
          end
          res.send_valid = 1'b1;
          res.send_port  = i[4:0];
          case (sent_cmd)
            CMD_HIGH: begin
              res.payload_first  = PAY_FIRST_HIGH;
              res.payload_second = PAY_SECOND_ON;
            end
            CMD_LOW: begin
              res.payload_first  = PAY_FIRST_LOW;
              res.payload_second = PAY_SECOND_ON;
            end
            default: ;
          endcase
          last_time = now;
          if (retries >= cfg_retry_limit) begin
            port_pending[i] = 1'b0;
            retries         = 4'd0;
          end
        end
      end
    end
    res.high_pins   = hi_pins;
    res.low_pins    = lo_pins;
    res.retry_count = retries;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one item and waits for the handshake
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic op, input logic [4:0] port, input logic [1:0] cmd,
                           input logic [31:0] now);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    port_i      <= port;
    command_i   <= cmd;
    now_i       <= now;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    due_results_q.push_back(apply_port_item(op, port, cmd, now));
  endtask

  // the block must be quiet before a register changes
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_PORT_COUNT:  cfg_port_count  = value[5:0];
      CFG_RETRY_GAP:   cfg_retry_gap   = value;
      CFG_RETRY_LIMIT: cfg_retry_limit = value[3:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [5:0] ports, input logic [7:0] gap,
                                input logic [3:0] limit);
    set_reg(CFG_PORT_COUNT, {2'b00, ports});
    set_reg(CFG_RETRY_GAP, gap);
    set_reg(CFG_RETRY_LIMIT, {4'd0, limit});
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, and a long hold-off when a test asks for it
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int stall_left = 0;
  int ready_gap;

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      ready_gap = idle_on ? pick_gap() : 0;
      if (ready_gap > 0) begin
        stall_left = ready_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    end
  endtask

  port_result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (due_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item with none expected, expected nothing, actual port %0d",
                 $realtime, send_port_o);
      end else begin
        want_res = due_results_q.pop_front();
        check_field("send_valid", 32'(want_res.send_valid), 32'(send_valid_o));
        check_field("send_port", 32'(want_res.send_port), 32'(send_port_o));
        check_field("payload_first", 32'(want_res.payload_first), 32'(payload_first_o));
        check_field("payload_second", 32'(want_res.payload_second), 32'(payload_second_o));
        check_field("high_side_pins", 32'(want_res.high_pins), 32'(high_side_pins_o));
        check_field("low_side_pins", 32'(want_res.low_pins), 32'(low_side_pins_o));
        check_field("shift_write", 32'(want_res.shift_write), 32'(shift_write_o));
        check_field("shift_word", want_res.shift_word, shift_word_o);
        check_field("retry_count", 32'(want_res.retry_count), 32'(retry_count_o));
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // service right after reset: nothing pending, default config
  task automatic test_idle_service();
    send_item(OP_SERVICE, 5'd31, CMD_UNUSED, 32'hFFFF_FFFF);
  endtask

  // pin pairs of the direct ports, high drives the low side
  task automatic test_direct_pins();
    send_item(OP_COMMAND, 5'd0, CMD_HIGH, 32'd0);
    send_item(OP_COMMAND, 5'd1, CMD_LOW, 32'd0);
    send_item(OP_COMMAND, 5'd2, CMD_OFF, 32'd0);
    send_item(OP_COMMAND, 5'd3, CMD_HIGH, 32'd0);
    // code three: pins and command unchanged, port still pending
    send_item(OP_COMMAND, 5'd3, CMD_UNUSED, 32'd0);
    send_item(OP_COMMAND, 5'd1, CMD_OFF, 32'd0);
  endtask

  // one-hot word of the shift ports, low and code three dropped there
  task automatic test_shift_word();
    send_item(OP_COMMAND, 5'd4, CMD_HIGH, 32'd0);
    send_item(OP_COMMAND, 5'd31, CMD_HIGH, 32'd0);
    send_item(OP_COMMAND, 5'd11, CMD_OFF, 32'd0);
    send_item(OP_COMMAND, 5'd12, CMD_LOW, 32'd0);
    send_item(OP_COMMAND, 5'd20, CMD_UNUSED, 32'd0);
  endtask

  // resends of the same port spaced past the gap, then across the tick wrap
  task automatic test_resend();
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd10);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd13);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd16);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd19);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'hFFFF_FFFE);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd2);
    // too soon after the last send: counter restarts
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd3);
  endtask

  // port count and retry limit at their extremes
  task automatic test_config_extremes();
    set_reg(CFG_PORT_COUNT, 8'd0);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd100);
    set_reg(CFG_PORT_COUNT, 8'd63);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd200);
    set_reg(CFG_RETRY_LIMIT, 8'd0);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd201);
    set_reg(CFG_PORT_COUNT, 8'd1);
    send_item(OP_SERVICE, 5'd0, CMD_OFF, 32'd202);
    set_reg(CFG_RETRY_GAP, 8'd255);
    set_reg(CFG_RETRY_LIMIT, 8'd15);
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_output_stall();
    idle_on      = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 24; k++) begin
      send_item(k[0] ? OP_SERVICE : OP_COMMAND, 5'(k), CMD_HIGH, 32'(k * 7));
    end
    idle_on = 1'b1;
  endtask

  // random commands then resends, with some noise items mixed in
  task automatic run_random_phase(input int item_total);
    int          sent;
    int          scan_end;
    int          burst;
    logic [4:0]  port;
    logic [1:0]  cmd;
    logic [31:0] tick;
    sent = 0;
    tick = $urandom();
    scan_end = (cfg_port_count > PORTS) ? PORTS : int'(cfg_port_count);
    while (sent < item_total) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        burst = 4;
      end else begin
        burst = 0;
      end
      // noise: any op, any port, any tick
      repeat (burst) begin
        port = 5'($urandom_range(0, PORTS - 1));
        cmd  = 2'($urandom_range(0, 3));
        if (cmd == CMD_UNUSED && port < DIRECT_PORTS && !cmd_written[port]) cmd = CMD_OFF;
        send_item(1'($urandom_range(0, 1)), port, cmd, $urandom());
        sent++;
      end
      if (burst == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if (scan_end > 0 && $urandom_range(0, 3) != 0) begin
            port = 5'($urandom_range(0, scan_end - 1));
          end else begin
            port = 5'($urandom_range(0, PORTS - 1));
          end
          cmd = ($urandom_range(0, 7) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
          if (cmd == CMD_UNUSED && port < DIRECT_PORTS && !cmd_written[port]) cmd = CMD_LOW;
          send_item(OP_COMMAND, port, cmd, tick);
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          // mostly far enough apart to count as a retry
          if ($urandom_range(0, 3) == 0) begin
            tick = tick + $urandom_range(0, cfg_retry_gap);
          end else begin
            tick = tick + cfg_retry_gap + $urandom_range(1, 3);
          end
          send_item(OP_SERVICE, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)), tick);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    apply_settings(6'd32, 8'd2, 4'd3);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'd1, 8'd0, 4'd1);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'd63, 8'd255, 4'd15);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'd5, 8'd10, 4'd0);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'd0, 8'd3, 4'd2);
    run_random_phase(PHASE_ITEMS / 2);
    apply_settings(6'd40, 8'd1, 4'd1);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'd17, 8'd0, 4'd4);
    run_random_phase(PHASE_ITEMS);
    apply_settings(6'($urandom_range(1, 32)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(1, 15)));
    run_random_phase(PHASE_ITEMS + PHASE_ITEMS / 2);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_service();
    test_direct_pins();
    test_shift_word();
    test_resend();
    test_config_extremes();
    test_output_stall();
    test_random();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
